@@ hdl/alb_pkg.sv @@
// Shared types and constants for the activity LED blinker.
package alb_pkg;

	typedef enum logic [2:0] {
		ACT_TICK       = 3'd0,
		ACT_RADIO_TX   = 3'd1,
		ACT_RADIO_RX   = 3'd2,
		ACT_SERIAL     = 3'd3,
		ACT_RADIO_ON   = 3'd4,
		ACT_RADIO_OFF  = 3'd5,
		ACT_SET_STATUS = 3'd6
	} action_t;

	localparam logic [1:0] ST_UNENUM   = 2'd0;
	localparam logic [1:0] ST_INACTIVE = 2'd1;
	localparam logic [1:0] ST_READY    = 2'd2;

	localparam logic [1:0] REG_ACT_PERIOD  = 2'd0;
	localparam logic [1:0] REG_FAST_PERIOD = 2'd1;
	localparam logic [1:0] REG_SLOW_PERIOD = 2'd2;

	localparam logic [15:0] ACT_PERIOD_RST  = 16'd4;
	localparam logic [15:0] FAST_PERIOD_RST = 16'd15;
	localparam logic [15:0] SLOW_PERIOD_RST = 16'd41;

	typedef struct packed {
		logic [1:0] new_status;
		action_t    action;
	} item_t;

	// bit 0 rx, bit 1 tx, bit 2 serial, bit 3 status
	typedef struct packed {
		logic status;
		logic serial;
		logic tx;
		logic rx;
	} leds_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  addr;
		logic [15:0] wdata;
	} cfg_wr_t;

endpackage

@@ hdl/alb_in_stage.sv @@
// Input register stage: captures one item and holds it until the engine takes it.
module alb_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [2:0] action, [4:3] new_status
	input  logic          advance,
	output logic          valid_s1,
	output alb_pkg::item_t item_s1
);
	import alb_pkg::*;

	always_comb begin
		s_tready = !valid_s1 || advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action     <= action_t'(s_tdata[2:0]);
			item_s1.new_status <= s_tdata[4:3];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("held item dropped");

endmodule

@@ hdl/alb_engine.sv @@
// Blinker state: counters, timers, status and the LED result register.
module alb_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  alb_pkg::cfg_wr_t cfg,
	input  logic            fire,
	input  alb_pkg::item_t  item,
	output alb_pkg::leds_t  leds_q
);
	import alb_pkg::*;

	logic [15:0] act_period_q, fast_period_q, slow_period_q;
	logic [15:0] act_cd_q, stat_cd_q, act_cd_n, stat_cd_n;
	logic [2:0]  rx_q, tx_q, rx_n, tx_n, dec3;
	logic [3:0]  ser_q, ser_n, dec4;
	logic        radio_q, radio_n;
	logic [1:0]  dev_q, dev_n;
	leds_t       leds_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_period_q  <= ACT_PERIOD_RST;
			fast_period_q <= FAST_PERIOD_RST;
			slow_period_q <= SLOW_PERIOD_RST;
		end else if (cfg.we) begin
			case (cfg.addr)
				REG_ACT_PERIOD:  act_period_q  <= cfg.wdata;
				REG_FAST_PERIOD: fast_period_q <= cfg.wdata;
				REG_SLOW_PERIOD: slow_period_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		rx_n      = rx_q;
		tx_n      = tx_q;
		ser_n     = ser_q;
		radio_n   = radio_q;
		dev_n     = dev_q;
		act_cd_n  = act_cd_q;
		stat_cd_n = stat_cd_q;
		leds_n    = leds_q;
		dec3      = 3'd0;
		dec4      = 4'd0;
		case (item.action)
			ACT_TICK: begin
				if (stat_cd_q <= 16'd1) begin
					if (dev_q == ST_READY) begin
						leds_n.status = 1'b1;
					end else begin
						leds_n.status = !leds_q.status;
					end
					stat_cd_n = (dev_q == ST_INACTIVE) ? fast_period_q : slow_period_q;
				end else begin
					stat_cd_n = stat_cd_q - 16'd1;
				end
				if (act_cd_q <= 16'd1) begin
					if (rx_q != 3'd0) begin
						rx_n      = rx_q - 3'd1;
						leds_n.rx = rx_n[1];
					end else begin
						leds_n.rx = 1'b0;
					end
					if (tx_q != 3'd0) begin
						tx_n      = tx_q - 3'd1;
						leds_n.tx = tx_n[1];
					end else begin
						leds_n.tx = 1'b0;
					end
					if (ser_q != 4'd0) begin
						ser_n         = ser_q - 4'd1;
						leds_n.serial = ser_n[2];
					end else begin
						leds_n.serial = 1'b0;
					end
					act_cd_n = act_period_q;
				end else begin
					act_cd_n = act_cd_q - 16'd1;
				end
			end
			ACT_RADIO_TX: begin
				tx_n = tx_q | 3'd4;
				dec3 = tx_n - 3'd1;
				if (dec3[1]) begin
					leds_n.tx = 1'b1;
				end
			end
			ACT_RADIO_RX: begin
				rx_n = rx_q | 3'd4;
				dec3 = rx_n - 3'd1;
				if (dec3[1]) begin
					leds_n.rx = 1'b1;
				end
			end
			ACT_SERIAL, ACT_RADIO_ON: begin
				if (item.action == ACT_SERIAL || !radio_q) begin
					ser_n = ser_q | 4'd8;
					dec4  = ser_n - 4'd1;
					if (dec4[2]) begin
						leds_n.serial = 1'b1;
					end
				end
				if (item.action == ACT_RADIO_ON) begin
					radio_n = 1'b1;
				end
			end
			ACT_RADIO_OFF: begin
				radio_n = 1'b0;
			end
			ACT_SET_STATUS: begin
				dev_n = item.new_status;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q      <= 3'd0;
			tx_q      <= 3'd0;
			ser_q     <= 4'd0;
			radio_q   <= 1'b0;
			dev_q     <= ST_UNENUM;
			act_cd_q  <= ACT_PERIOD_RST;
			stat_cd_q <= FAST_PERIOD_RST;
			leds_q    <= '0;
		end else if (fire) begin
			rx_q      <= rx_n;
			tx_q      <= tx_n;
			ser_q     <= ser_n;
			radio_q   <= radio_n;
			dev_q     <= dev_n;
			act_cd_q  <= act_cd_n;
			stat_cd_q <= stat_cd_n;
			leds_q    <= leds_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(leds_q) && $stable(ser_q))
		else $error("state moved without an item");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.action == ACT_TICK && act_cd_q > 16'd1)
		|=> act_cd_q == $past(act_cd_q) - 16'd1)
		else $error("activity timer did not count down");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item.action == ACT_TICK && act_cd_q <= 16'd1 && ser_q == 4'd0)
		|=> !leds_q.serial)
		else $error("idle serial LED left lit");

endmodule

@@ hdl/activity_led_blinker_unit.sv @@
// Top level of the activity LED blinker.
//
//  channel | signals                               | item
//  --------+---------------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata[7:0]        | action, new_status
//  m_      | m_tvalid m_tready m_tdata[7:0]        | rx, tx, serial, status LEDs
//  cfg_    | cfg_valid cfg_ready cfg_addr cfg_wdata| period register write
//
// One item per cycle while the result is taken; an item passes the input
// register, then the state update into the result register.
// Reset clears all counters and LEDs and loads the timers with their default periods.
// A stalled result holds the engine; one more item waits in the input register.
// Period writes are always accepted and take effect at the next timer reload.
module activity_led_blinker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] action, [4:3] new_status, [7:5] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] rx_led, [1] tx_led, [2] serial_led, [3] status_led
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import alb_pkg::*;

	logic    valid_s1, advance, fire, out_valid_q;
	item_t   item_s1;
	leds_t   leds;
	cfg_wr_t cfg;

	always_comb begin
		advance      = !out_valid_q || m_tready;
		fire         = valid_s1 && advance;
		cfg_ready    = 1'b1;
		cfg.we       = cfg_valid;
		cfg.addr     = cfg_addr;
		cfg.wdata    = cfg_wdata;
		m_tvalid     = out_valid_q;
		m_tdata      = {4'd0, leds};
	end

	alb_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	alb_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.leds_q (leds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted item not registered");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item produced no result");

endmodule

@@ test/activity_led_blinker_checker.sv @@
`timescale 1ns / 100ps
// Checker for the activity LED blinker: tracks the channels, predicts the LEDs and compares.
module activity_led_blinker_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] action, [4:3] new_status, [7:5] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [0] rx_led, [1] tx_led, [2] serial_led, [3] status_led
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          pending,
	output int          checked
);
	import alb_pkg::*;

	logic [15:0] act_period;
	logic [15:0] fast_period;
	logic [15:0] slow_period;

	logic [2:0]  rx_cnt;
	logic [2:0]  tx_cnt;
	logic [3:0]  ser_cnt;
	leds_t       leds;
	logic        radio_on;
	logic [1:0]  dev_status;
	logic [15:0] act_cd;
	logic [15:0] stat_cd;

	leds_t expected_leds[$];

	// status timer first, then the activity timer
	task automatic base_tick();
		if (stat_cd <= 16'd1) begin
			if (dev_status == ST_READY)
				leds.status = 1'b1;
			else
				leds.status = ~leds.status;
			stat_cd = (dev_status == ST_INACTIVE) ? fast_period : slow_period;
		end else begin
			stat_cd = stat_cd - 16'd1;
		end

		if (act_cd <= 16'd1) begin
			if (rx_cnt != 3'd0)
				rx_cnt = rx_cnt - 3'd1;
			if (tx_cnt != 3'd0)
				tx_cnt = tx_cnt - 3'd1;
			if (ser_cnt != 4'd0)
				ser_cnt = ser_cnt - 4'd1;
			leds.rx     = rx_cnt[1];
			leds.tx     = tx_cnt[1];
			leds.serial = ser_cnt[2];
			act_cd = act_period;
		end else begin
			act_cd = act_cd - 16'd1;
		end
	endtask

	task automatic serial_activity();
		ser_cnt = ser_cnt | 4'b1000;
		if (((ser_cnt - 4'd1) & 4'b0100) != 4'd0)
			leds.serial = 1'b1;
	endtask

	task automatic apply_action(input logic [2:0] act, input logic [1:0] st);
		case (act)
			ACT_TICK: begin
				base_tick();
			end
			ACT_RADIO_TX: begin
				tx_cnt = tx_cnt | 3'b100;
				if (((tx_cnt - 3'd1) & 3'b010) != 3'd0)
					leds.tx = 1'b1;
			end
			ACT_RADIO_RX: begin
				rx_cnt = rx_cnt | 3'b100;
				if (((rx_cnt - 3'd1) & 3'b010) != 3'd0)
					leds.rx = 1'b1;
			end
			ACT_SERIAL: begin
				serial_activity();
			end
			ACT_RADIO_ON: begin
				if (!radio_on)
					serial_activity();
				radio_on = 1'b1;
			end
			ACT_RADIO_OFF: begin
				radio_on = 1'b0;
			end
			ACT_SET_STATUS: begin
				dev_status = st;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		leds_t got;
		leds_t want;
		if (!arst_n) begin
			act_period  = ACT_PERIOD_RST;
			fast_period = FAST_PERIOD_RST;
			slow_period = SLOW_PERIOD_RST;
			rx_cnt      = 3'd0;
			tx_cnt      = 3'd0;
			ser_cnt     = 4'd0;
			leds        = '0;
			radio_on    = 1'b0;
			dev_status  = ST_UNENUM;
			act_cd      = ACT_PERIOD_RST;
			stat_cd     = FAST_PERIOD_RST;
			expected_leds.delete();
			errors  = 0;
			checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					REG_ACT_PERIOD:  act_period  = cfg_wdata;
					REG_FAST_PERIOD: fast_period = cfg_wdata;
					REG_SLOW_PERIOD: slow_period = cfg_wdata;
					default: begin
					end
				endcase
			end

			if (m_tvalid && m_tready) begin
				got = m_tdata[3:0];
				if (expected_leds.size() == 0) begin
					$error("LED item with none expected: %b", m_tdata[3:0]);
					errors++;
				end else begin
					want = expected_leds.pop_front();
					checked++;
					if (got.rx !== want.rx) begin
						$error("rx_led: expected %0b, got %0b", want.rx, got.rx);
						errors++;
					end
					if (got.tx !== want.tx) begin
						$error("tx_led: expected %0b, got %0b", want.tx, got.tx);
						errors++;
					end
					if (got.serial !== want.serial) begin
						$error("serial_led: expected %0b, got %0b", want.serial, got.serial);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status_led: expected %0b, got %0b", want.status, got.status);
						errors++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				apply_action(s_tdata[2:0], s_tdata[4:3]);
				expected_leds.push_back(leds);
			end
		end
		pending = expected_leds.size();
	end

endmodule

@@ test/activity_led_blinker_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the activity LED blinker: stimulus, idling, watchdog and verdict.
module activity_led_blinker_unit_tb;
	import alb_pkg::*;

	localparam logic [2:0] ACT_UNUSED    = 3'd7;
	localparam logic [1:0] ST_CODE_THREE = 2'd3;
	localparam int         STALL_LIMIT   = 1000;
	localparam int         PHASE_ITEMS   = 165;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr  = REG_ACT_PERIOD;
	logic [15:0] cfg_wdata = 16'd0;

	int errors;
	int pending;
	int checked;
	int items_sent  = 0;
	int reg_writes  = 0;
	int settings    = 1;
	int quiet_cycles = 0;
	bit steady      = 1'b0;

	activity_led_blinker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	activity_led_blinker_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 18);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send(input logic [2:0] act, input logic [1:0] st);
		while (!steady && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, st, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_periods(input logic [15:0] act_p, input logic [15:0] fast_p,
			input logic [15:0] slow_p, input bit no_idle);
		drain();
		write_reg(REG_ACT_PERIOD, act_p);
		write_reg(REG_FAST_PERIOD, fast_p);
		write_reg(REG_SLOW_PERIOD, slow_p);
		cfg_valid <= 1'b0;
		steady = no_idle;
		settings++;
	endtask

	task automatic random_items(input int count);
		int r;
		logic [1:0] st;
		repeat (count) begin
			r  = $urandom_range(0, 99);
			st = 2'($urandom_range(0, 3));
			if (r < 50)
				send(ACT_TICK, st);
			else if (r < 60)
				send(ACT_RADIO_TX, st);
			else if (r < 70)
				send(ACT_RADIO_RX, st);
			else if (r < 78)
				send(ACT_SERIAL, st);
			else if (r < 84)
				send(ACT_RADIO_ON, st);
			else if (r < 89)
				send(ACT_RADIO_OFF, st);
			else if (r < 97) begin
				if ($urandom_range(0, 9) == 0)
					st = ST_CODE_THREE;
				else
					st = 2'($urandom_range(0, 2));
				send(ACT_SET_STATUS, st);
			end else
				send(ACT_UNUSED, st);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// events, radio on only from off, every status code, unused code
		send(ACT_RADIO_TX, ST_UNENUM);
		send(ACT_RADIO_RX, ST_CODE_THREE);
		send(ACT_SERIAL, ST_READY);
		send(ACT_RADIO_ON, ST_UNENUM);
		send(ACT_RADIO_ON, ST_UNENUM);
		send(ACT_RADIO_OFF, ST_INACTIVE);
		send(ACT_RADIO_ON, ST_UNENUM);
		send(ACT_SET_STATUS, ST_READY);
		repeat (4) send(ACT_TICK, ST_CODE_THREE);
		send(ACT_SET_STATUS, ST_INACTIVE);
		repeat (4) send(ACT_TICK, ST_UNENUM);
		send(ACT_SET_STATUS, ST_CODE_THREE);
		send(ACT_UNUSED, ST_CODE_THREE);
		send(ACT_SET_STATUS, ST_UNENUM);
		repeat (4) send(ACT_TICK, ST_READY);

		random_items(PHASE_ITEMS);

		set_periods(16'd1, 16'd1, 16'd1, 1'b1);
		random_items(PHASE_ITEMS);

		// zero period acts like one
		set_periods(16'd0, 16'd2, 16'd0, 1'b0);
		random_items(PHASE_ITEMS);

		repeat (3) begin
			set_periods(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 12)), 1'b0);
			random_items(PHASE_ITEMS / 2);
			drain();
			random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
		end

		set_periods(16'd3, 16'hFFFF, 16'hFFFF, 1'b0);
		random_items(PHASE_ITEMS);

		set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		random_items(PHASE_ITEMS);

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d items (ticks, radio and serial events, status codes) under %0d",
			items_sent, settings);
		$display("period settings with %0d register writes; %0d LED items compared.",
			reg_writes, checked);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/alb_pkg.sv
hdl/alb_in_stage.sv
hdl/alb_engine.sv
hdl/activity_led_blinker_unit.sv
test/activity_led_blinker_checker.sv
test/activity_led_blinker_unit_tb.sv
